FILE: hdl/look_at_view_matrix_core_defines.svh
// Assertion macros shared by the checker files of the look-at view matrix core.
`ifndef LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LAVM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LAVM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lavm_pkg.sv
// Shared constants, types and helper functions of the look-at view matrix core.
`default_nettype none

package lavm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW = 32;

    // Magnitudes before and after the normalizing shift.
    localparam int MAGW = 32;
    localparam int MW = 30;
    localparam int POSW = $clog2(MAGW);
    localparam int RSHW = $clog2(MAGW - MW + 1);
    localparam int LSHW = $clog2(MW);

    // Square root of the sum of squares.
    localparam int SQW = 2 * MW;
    localparam int SUMW = SQW + 2;
    localparam int RTW = SUMW + 1;
    localparam int SQRT_STEPS = SUMW / 2 + 1;
    localparam int LENW = MW + 1;

    // Restoring divide for the unit components.
    localparam int REMW = LENW + 1;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 1;

    localparam int CNTW = $clog2(SQRT_STEPS);
    localparam logic [CNTW-1:0] SQRT_LAST = CNTW'(SQRT_STEPS - 1);
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(DIV_STEPS - 1);

    // Signed widths of the unit vectors, left, true up and the products.
    localparam int NW = FRAC_BITS + 2;
    localparam int LW = FRAC_BITS + 3;
    localparam int TW = FRAC_BITS + 4;
    localparam int P1W = 2 * NW;
    localparam int P2W = LW + NW;
    localparam int DPW = 2 * DW;
    localparam int SATW = DPW + 2;

    // The queue depth must be a power of two.
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    localparam int ROWS = 3;
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST = 2'(ROWS - 1);

    localparam logic signed [SATW-1:0] SAT_MAX = SATW'(2147483647);
    localparam logic signed [SATW-1:0] SAT_MIN = -SAT_MAX - SATW'(1);

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
        logic               zero;
    } nvec_t;

    typedef struct packed {
        nvec_t              fwd;
        nvec_t              up;
        logic [2:0][DW-1:0] eye;
    } qword_t;

    typedef struct packed {
        logic [3:0][DW-1:0] col;
    } row_t;

    typedef struct packed {
        row_t [2:0] row;
        logic       degenerate;
    } eword_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQ,
        B_SUM,
        B_SQRT,
        B_DIV,
        B_C1M,
        B_C1S,
        B_C2M,
        B_C2S,
        B_DOTM,
        B_DOTS,
        B_OUT
    } bstate_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [SATW-1:0] v);
        if (v > SAT_MAX)
        begin
            return DW'(SAT_MAX);
        end
        if (v < SAT_MIN)
        begin
            return DW'(SAT_MIN);
        end
        return DW'(v);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lavm_in_if.sv
// Input channel interface: eye point, target point and up vector of one word.
`default_nettype none

interface lavm_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [lavm_pkg::DW-1:0]    from_x;
    logic signed [lavm_pkg::DW-1:0]    from_y;
    logic signed [lavm_pkg::DW-1:0]    from_z;
    logic signed [lavm_pkg::DW-1:0]    to_x;
    logic signed [lavm_pkg::DW-1:0]    to_y;
    logic signed [lavm_pkg::DW-1:0]    to_z;
    logic signed [lavm_pkg::DW-1:0]    up_x;
    logic signed [lavm_pkg::DW-1:0]    up_y;
    logic signed [lavm_pkg::DW-1:0]    up_z;

    modport source (
        output valid, from_x, from_y, from_z, to_x, to_y, to_z, up_x, up_y, up_z,
        input  ready
    );

    modport sink (
        input  valid, from_x, from_y, from_z, to_x, to_y, to_z, up_x, up_y, up_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/lavm_out_if.sv
// Output channel interface: one row of the view matrix per word.
`default_nettype none

interface lavm_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        row_index;
    logic signed [lavm_pkg::DW-1:0]    col0;
    logic signed [lavm_pkg::DW-1:0]    col1;
    logic signed [lavm_pkg::DW-1:0]    col2;
    logic signed [lavm_pkg::DW-1:0]    col3;
    logic                              degenerate;
    logic                              last_row;

    modport source (
        output valid, row_index, col0, col1, col2, col3, degenerate, last_row,
        input  ready
    );

    modport sink (
        input  valid, row_index, col0, col1, col2, col3, degenerate, last_row,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/lavm_front.sv
// Front end: forms the difference vector, magnitudes and the normalizing shift.
`default_nettype none

module lavm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lavm_in_if.sink             req,
    output logic                q_push,
    output lavm_pkg::qword_t    q_data,
    input  wire logic           q_ready
);

    logic                          en1;
    logic                          en2;
    logic signed [lavm_pkg::DW-1:0] frm [3];
    logic signed [lavm_pkg::DW-1:0] tgt [3];
    logic signed [lavm_pkg::DW-1:0] upv [3];
    logic signed [lavm_pkg::DW:0]   diff [3];

    logic                          s1_v_reg;
    logic [lavm_pkg::MAGW-1:0]     s1_fm_reg [3];
    logic [lavm_pkg::MAGW-1:0]     s1_um_reg [3];
    logic [2:0]                    s1_fn_reg;
    logic [2:0]                    s1_un_reg;
    logic [lavm_pkg::DW-1:0]       s1_eye_reg [3];

    logic [lavm_pkg::MAGW-1:0]     f_or;
    logic [lavm_pkg::MAGW-1:0]     u_or;
    logic [lavm_pkg::POSW-1:0]     f_pos;
    logic [lavm_pkg::POSW-1:0]     u_pos;

    logic                          s2_v_reg;
    logic [lavm_pkg::MAGW-1:0]     s2_fm_reg [3];
    logic [lavm_pkg::MAGW-1:0]     s2_um_reg [3];
    logic [2:0]                    s2_fn_reg;
    logic [2:0]                    s2_un_reg;
    logic                          s2_fz_reg;
    logic                          s2_uz_reg;
    logic [lavm_pkg::RSHW-1:0]     s2_frsh_reg;
    logic [lavm_pkg::LSHW-1:0]     s2_flsh_reg;
    logic [lavm_pkg::RSHW-1:0]     s2_ursh_reg;
    logic [lavm_pkg::LSHW-1:0]     s2_ulsh_reg;
    logic [lavm_pkg::DW-1:0]       s2_eye_reg [3];

    function automatic logic [lavm_pkg::MAGW-1:0] mag_of(
        input logic signed [lavm_pkg::DW:0] v
    );
        logic signed [lavm_pkg::DW:0] n;
        n = -v;
        return v[lavm_pkg::DW] ? lavm_pkg::MAGW'(n) : lavm_pkg::MAGW'(v);
    endfunction

    function automatic logic [lavm_pkg::POSW-1:0] lead_pos(
        input logic [lavm_pkg::MAGW-1:0] v
    );
        logic [lavm_pkg::POSW-1:0] p;
        p = '0;
        for (int i = 0; i < lavm_pkg::MAGW; i++)
        begin
            if (v[i])
            begin
                p = lavm_pkg::POSW'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [lavm_pkg::RSHW-1:0] rsh_of(
        input logic [lavm_pkg::POSW-1:0] p
    );
        logic [lavm_pkg::POSW-1:0] top;
        top = lavm_pkg::POSW'(lavm_pkg::MW - 1);
        return (p > top) ? lavm_pkg::RSHW'(p - top) : '0;
    endfunction

    function automatic logic [lavm_pkg::LSHW-1:0] lsh_of(
        input logic [lavm_pkg::POSW-1:0] p
    );
        logic [lavm_pkg::POSW-1:0] top;
        top = lavm_pkg::POSW'(lavm_pkg::MW - 1);
        return (p < top) ? lavm_pkg::LSHW'(top - p) : '0;
    endfunction

    function automatic logic [lavm_pkg::MW-1:0] scale(
        input logic [lavm_pkg::MAGW-1:0] m,
        input logic [lavm_pkg::RSHW-1:0] r,
        input logic [lavm_pkg::LSHW-1:0] s
    );
        logic [lavm_pkg::MAGW-1:0] t;
        t = (m >> r) << s;
        return lavm_pkg::MW'(t);
    endfunction

    assign en2 = !s2_v_reg || q_ready;
    assign en1 = !s1_v_reg || en2;
    assign req.ready = en1;

    always_comb
    begin
        frm[0] = req.from_x;
        frm[1] = req.from_y;
        frm[2] = req.from_z;
        tgt[0] = req.to_x;
        tgt[1] = req.to_y;
        tgt[2] = req.to_z;
        upv[0] = req.up_x;
        upv[1] = req.up_y;
        upv[2] = req.up_z;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = (lavm_pkg::DW + 1)'(tgt[i]) - (lavm_pkg::DW + 1)'(frm[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= req.valid;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_fm_reg[i]  <= mag_of(diff[i]);
                s1_um_reg[i]  <= mag_of((lavm_pkg::DW + 1)'(upv[i]));
                s1_fn_reg[i]  <= diff[i][lavm_pkg::DW];
                s1_un_reg[i]  <= upv[i][lavm_pkg::DW-1];
                s1_eye_reg[i] <= frm[i];
            end
        end
    end

    // The leading one of the OR of the magnitudes is the leading one of the largest.
    assign f_or  = s1_fm_reg[0] | s1_fm_reg[1] | s1_fm_reg[2];
    assign u_or  = s1_um_reg[0] | s1_um_reg[1] | s1_um_reg[2];
    assign f_pos = lead_pos(f_or);
    assign u_pos = lead_pos(u_or);

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_fm_reg[i]  <= s1_fm_reg[i];
                s2_um_reg[i]  <= s1_um_reg[i];
                s2_eye_reg[i] <= s1_eye_reg[i];
            end
            s2_fn_reg   <= s1_fn_reg;
            s2_un_reg   <= s1_un_reg;
            s2_fz_reg   <= (f_or == '0);
            s2_uz_reg   <= (u_or == '0);
            s2_frsh_reg <= rsh_of(f_pos);
            s2_flsh_reg <= lsh_of(f_pos);
            s2_ursh_reg <= rsh_of(u_pos);
            s2_ulsh_reg <= lsh_of(u_pos);
        end
    end

    assign q_push = s2_v_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_data.fwd.mag[i] = scale(s2_fm_reg[i], s2_frsh_reg, s2_flsh_reg);
            q_data.up.mag[i]  = scale(s2_um_reg[i], s2_ursh_reg, s2_ulsh_reg);
            q_data.eye[i]     = s2_eye_reg[i];
        end
        q_data.fwd.neg  = s2_fn_reg;
        q_data.up.neg   = s2_un_reg;
        q_data.fwd.zero = s2_fz_reg;
        q_data.up.zero  = s2_uz_reg;
    end

endmodule

`default_nettype wire

FILE: hdl/lavm_queue.sv
// Short queue of classified words between the front end and the back end.
`default_nettype none

module lavm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  lavm_pkg::qword_t    push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output lavm_pkg::qword_t    pop_data,
    input  wire logic           pop
);

    lavm_pkg::qword_t            slot_reg [lavm_pkg::QDEPTH];
    logic [lavm_pkg::QAW-1:0]    wr_ptr_reg;
    logic [lavm_pkg::QAW-1:0]    rd_ptr_reg;
    logic [lavm_pkg::QAW:0]      count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != (lavm_pkg::QAW + 1)'(lavm_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lavm_back.sv
// Back end: square roots, divides, cross products and dot products of one word.
`default_nettype none

module lavm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  lavm_pkg::qword_t    q_data,
    output logic                q_pop,
    output logic                e_valid,
    output lavm_pkg::eword_t    e_data,
    input  wire logic           e_ready
);

    lavm_pkg::bstate_t state_reg;
    lavm_pkg::bstate_t state_next;
    logic [lavm_pkg::CNTW-1:0] cnt_reg;

    logic [lavm_pkg::MW-1:0]          mag_reg  [2][3];
    logic                             neg_reg  [2][3];
    logic                             zero_reg [2];
    logic signed [lavm_pkg::DW-1:0]   eye_reg  [3];
    logic [lavm_pkg::SQW-1:0]         sq_reg   [2][3];
    logic [lavm_pkg::SUMW-1:0]        rem_reg  [2];
    logic [lavm_pkg::RTW-1:0]         root_reg [2];
    logic [lavm_pkg::RTW-1:0]         bit_reg;
    logic [lavm_pkg::REMW-1:0]        drem_reg [2][3];
    logic [lavm_pkg::QW-1:0]          quo_reg  [2][3];
    logic signed [lavm_pkg::P1W-1:0]  p1_reg   [6];
    logic signed [lavm_pkg::LW-1:0]   left_reg [3];
    logic signed [lavm_pkg::P2W-1:0]  p2_reg   [6];
    logic signed [lavm_pkg::DW-1:0]   row_reg  [3][3];
    logic signed [lavm_pkg::DPW-1:0]  dp_reg   [3][3];
    lavm_pkg::eword_t                 e_data_reg;

    logic [lavm_pkg::RTW-1:0]         sq_try  [2];
    logic                             sq_ge   [2];
    logic [lavm_pkg::REMW-1:0]        dv_len  [2];
    logic [lavm_pkg::REMW-1:0]        dv_sub  [2][3];
    logic                             dv_ge   [2][3];
    logic signed [lavm_pkg::NW-1:0]   unit    [2][3];
    logic signed [lavm_pkg::TW-1:0]   tup     [3];
    logic signed [lavm_pkg::SATW-1:0] dsum    [3];

    function automatic logic signed [lavm_pkg::NW-1:0] to_unit(
        input logic [lavm_pkg::QW-1:0] q,
        input logic                    neg,
        input logic                    zero
    );
        logic signed [lavm_pkg::NW-1:0] v;
        v = signed'(lavm_pkg::NW'(q));
        if (zero)
        begin
            return '0;
        end
        return neg ? -v : v;
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lavm_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = lavm_pkg::B_SQ;
                end
            end
            lavm_pkg::B_SQ:   state_next = lavm_pkg::B_SUM;
            lavm_pkg::B_SUM:  state_next = lavm_pkg::B_SQRT;
            lavm_pkg::B_SQRT:
            begin
                if (cnt_reg == lavm_pkg::SQRT_LAST)
                begin
                    state_next = lavm_pkg::B_DIV;
                end
            end
            lavm_pkg::B_DIV:
            begin
                if (cnt_reg == lavm_pkg::DIV_LAST)
                begin
                    state_next = lavm_pkg::B_C1M;
                end
            end
            lavm_pkg::B_C1M:  state_next = lavm_pkg::B_C1S;
            lavm_pkg::B_C1S:  state_next = lavm_pkg::B_C2M;
            lavm_pkg::B_C2M:  state_next = lavm_pkg::B_C2S;
            lavm_pkg::B_C2S:  state_next = lavm_pkg::B_DOTM;
            lavm_pkg::B_DOTM: state_next = lavm_pkg::B_DOTS;
            lavm_pkg::B_DOTS: state_next = lavm_pkg::B_OUT;
            lavm_pkg::B_OUT:
            begin
                if (e_ready)
                begin
                    state_next = lavm_pkg::B_IDLE;
                end
            end
            default:          state_next = lavm_pkg::B_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        q_pop   = 1'b0;
        e_valid = 1'b0;
        case (state_reg)
            lavm_pkg::B_IDLE: q_pop   = q_valid;
            lavm_pkg::B_OUT:  e_valid = 1'b1;
            default:
            begin
                q_pop   = 1'b0;
                e_valid = 1'b0;
            end
        endcase
    end

    assign e_data = e_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lavm_pkg::B_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lavm_pkg::B_SUM ||
                (state_reg == lavm_pkg::B_SQRT && cnt_reg == lavm_pkg::SQRT_LAST) ||
                (state_reg == lavm_pkg::B_DIV && cnt_reg == lavm_pkg::DIV_LAST))
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == lavm_pkg::B_SQRT || state_reg == lavm_pkg::B_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sq_try[l] = root_reg[l] + bit_reg;
            sq_ge[l]  = (lavm_pkg::RTW'(rem_reg[l]) >= sq_try[l]);
            dv_len[l] = lavm_pkg::REMW'(root_reg[l][lavm_pkg::LENW-1:0]);
            for (int i = 0; i < 3; i++)
            begin
                dv_ge[l][i]  = (drem_reg[l][i] >= dv_len[l]);
                dv_sub[l][i] = dv_ge[l][i] ? (drem_reg[l][i] - dv_len[l]) : drem_reg[l][i];
                unit[l][i]   = to_unit(quo_reg[l][i], neg_reg[l][i], zero_reg[l]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            tup[k] = lavm_pkg::TW'(((lavm_pkg::P2W + 1)'(p2_reg[2*k]) -
                                    (lavm_pkg::P2W + 1)'(p2_reg[2*k+1])) >>> lavm_pkg::FRAC_BITS);
            dsum[k] = lavm_pkg::SATW'(dp_reg[k][0] >>> lavm_pkg::FRAC_BITS) +
                      lavm_pkg::SATW'(dp_reg[k][1] >>> lavm_pkg::FRAC_BITS) +
                      lavm_pkg::SATW'(dp_reg[k][2] >>> lavm_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lavm_pkg::B_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[0][i] <= q_data.fwd.mag[i];
                    mag_reg[1][i] <= q_data.up.mag[i];
                    neg_reg[0][i] <= q_data.fwd.neg[i];
                    neg_reg[1][i] <= q_data.up.neg[i];
                    eye_reg[i]    <= q_data.eye[i];
                end
                zero_reg[0] <= q_data.fwd.zero;
                zero_reg[1] <= q_data.up.zero;
            end
            lavm_pkg::B_SQ:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sq_reg[l][i] <= lavm_pkg::SQW'(mag_reg[l][i]) *
                                        lavm_pkg::SQW'(mag_reg[l][i]);
                    end
                end
            end
            lavm_pkg::B_SUM:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l]  <= lavm_pkg::SUMW'(sq_reg[l][0]) + lavm_pkg::SUMW'(sq_reg[l][1]) +
                                   lavm_pkg::SUMW'(sq_reg[l][2]);
                    root_reg[l] <= '0;
                end
                bit_reg <= lavm_pkg::RTW'(1) << lavm_pkg::SUMW;
            end
            lavm_pkg::B_SQRT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    if (sq_ge[l])
                    begin
                        rem_reg[l]  <= lavm_pkg::SUMW'(lavm_pkg::RTW'(rem_reg[l]) - sq_try[l]);
                        root_reg[l] <= (root_reg[l] >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg[l] <= root_reg[l] >> 1;
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        drem_reg[l][i] <= lavm_pkg::REMW'(mag_reg[l][i]);
                        quo_reg[l][i]  <= '0;
                    end
                end
                bit_reg <= bit_reg >> 2;
            end
            lavm_pkg::B_DIV:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        drem_reg[l][i] <= dv_sub[l][i] << 1;
                        quo_reg[l][i]  <= {quo_reg[l][i][lavm_pkg::QW-2:0], dv_ge[l][i]};
                    end
                end
            end
            lavm_pkg::B_C1M:
            begin
                p1_reg[0] <= unit[0][1] * unit[1][2];
                p1_reg[1] <= unit[0][2] * unit[1][1];
                p1_reg[2] <= unit[0][2] * unit[1][0];
                p1_reg[3] <= unit[0][0] * unit[1][2];
                p1_reg[4] <= unit[0][0] * unit[1][1];
                p1_reg[5] <= unit[0][1] * unit[1][0];
            end
            lavm_pkg::B_C1S:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    left_reg[k] <= lavm_pkg::LW'(((lavm_pkg::P1W + 1)'(p1_reg[2*k]) -
                                                  (lavm_pkg::P1W + 1)'(p1_reg[2*k+1]))
                                                 >>> lavm_pkg::FRAC_BITS);
                end
            end
            lavm_pkg::B_C2M:
            begin
                p2_reg[0] <= left_reg[1] * unit[0][2];
                p2_reg[1] <= left_reg[2] * unit[0][1];
                p2_reg[2] <= left_reg[2] * unit[0][0];
                p2_reg[3] <= left_reg[0] * unit[0][2];
                p2_reg[4] <= left_reg[0] * unit[0][1];
                p2_reg[5] <= left_reg[1] * unit[0][0];
            end
            lavm_pkg::B_C2S:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    row_reg[0][i] <= lavm_pkg::sat32(lavm_pkg::SATW'(left_reg[i]));
                    row_reg[1][i] <= lavm_pkg::sat32(lavm_pkg::SATW'(tup[i]));
                    row_reg[2][i] <= lavm_pkg::sat32(-lavm_pkg::SATW'(unit[0][i]));
                end
            end
            lavm_pkg::B_DOTM:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dp_reg[r][i] <= row_reg[r][i] * eye_reg[i];
                    end
                end
            end
            lavm_pkg::B_DOTS:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e_data_reg.row[r].col[i] <= row_reg[r][i];
                    end
                    e_data_reg.row[r].col[3] <= lavm_pkg::sat32(-dsum[r]);
                end
                e_data_reg.degenerate <= zero_reg[0] || zero_reg[1];
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/lavm_emit.sv
// Output stage: holds one finished matrix and hands it out one row per word.
`default_nettype none

module lavm_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           e_valid,
    input  lavm_pkg::eword_t    e_data,
    output logic                e_ready,
    lavm_out_if.source          rsp
);

    lavm_pkg::eword_t buf_reg;
    logic             full_reg;
    logic [1:0]       cnt_reg;
    logic             take;
    logic             last;

    assign take    = rsp.valid && rsp.ready;
    assign last    = (cnt_reg == lavm_pkg::ROW_LAST);
    assign e_ready = !full_reg || (take && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            cnt_reg  <= lavm_pkg::ROW_FIRST;
        end
        else if (e_valid && e_ready)
        begin
            full_reg <= 1'b1;
            cnt_reg  <= lavm_pkg::ROW_FIRST;
        end
        else if (take)
        begin
            if (last)
            begin
                full_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_valid && e_ready)
        begin
            buf_reg <= e_data;
        end
    end

    assign rsp.valid      = full_reg;
    assign rsp.row_index  = cnt_reg;
    assign rsp.col0       = buf_reg.row[cnt_reg].col[0];
    assign rsp.col1       = buf_reg.row[cnt_reg].col[1];
    assign rsp.col2       = buf_reg.row[cnt_reg].col[2];
    assign rsp.col3       = buf_reg.row[cnt_reg].col[3];
    assign rsp.degenerate = buf_reg.degenerate;
    assign rsp.last_row   = last;

endmodule

`default_nettype wire

FILE: hdl/look_at_view_matrix_core.sv
// Top level of the fixed-point look-at view matrix core.
//
// Each input word carries an eye point, a target point and an up vector in
// signed fixed point with lavm_pkg::FRAC_BITS fraction bits. For each word the
// core returns three output words, the rows left, true up and negated forward
// of the view matrix, each with a fourth entry of minus the row's dot product
// with the eye point. Entries saturate to the signed 32-bit range, and the
// degenerate flag is set on all three rows when the target equals the eye or
// the up vector is zero. For each word the back end runs a 32-step square
// root and a FRAC_BITS + 1 step restoring divide (FRAC_BITS is 16 at Q16.16)
// for both vectors at once, then the products and the hand-off. The front end
// takes a new word every cycle until its four-word queue fills, and the three
// rows of one matrix leave the output stage while the back end already works
// on the next word.

`default_nettype none

module look_at_view_matrix_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lavm_in_if.sink     req,
    lavm_out_if.source  rsp
);

    // Front end to queue.
    logic               f_push;
    lavm_pkg::qword_t   f_data;
    logic               f_ready;

    // Queue to back end.
    logic               q_valid;
    lavm_pkg::qword_t   q_data;
    logic               q_pop;

    // Back end to output stage.
    logic               e_valid;
    lavm_pkg::eword_t   e_data;
    logic               e_ready;

    // The front end computes the difference vector and the shift that puts the
    // largest magnitude of each vector just below 2^30.
    lavm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_push  (f_push),
        .q_data  (f_data),
        .q_ready (f_ready)
    );

    lavm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_data  (f_data),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop        (q_pop)
    );

    // The back end normalizes both vectors, takes the two cross products and
    // the eye dot products, and hands a whole matrix to the output stage.
    lavm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .e_valid (e_valid),
        .e_data  (e_data),
        .e_ready (e_ready)
    );

    lavm_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .e_valid (e_valid),
        .e_data  (e_data),
        .e_ready (e_ready),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

FILE: hdl/lavm_checker.sv
// Port checker of the look-at view matrix core and its bind statement.
`default_nettype none
`include "look_at_view_matrix_core_defines.svh"

module lavm_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire logic [1:0]                out_row_index,
    input  wire logic [lavm_pkg::DW-1:0]   out_col0,
    input  wire logic [lavm_pkg::DW-1:0]   out_col1,
    input  wire logic [lavm_pkg::DW-1:0]   out_col2,
    input  wire logic [lavm_pkg::DW-1:0]   out_col3,
    input  wire logic                      out_degenerate,
    input  wire logic                      out_last_row
);

    // A stalled row holds still.
    `LAVM_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_row_index) && $stable(out_col0) && $stable(out_col1) && $stable(out_col2) && $stable(out_col3) && $stable(out_degenerate), "stalled row changed")

    // The final-row flag marks the third row and only it.
    `LAVM_ASSERT_IMP(a_last, out_valid, out_last_row == (out_row_index == lavm_pkg::ROW_LAST), "last_row does not match row_index")

    // Rows of one matrix follow without a gap and share the degenerate flag.
    `LAVM_ASSERT_NXT(a_order, out_valid && out_ready && !out_last_row, out_valid && (out_row_index == $past(out_row_index) + 2'd1) && (out_degenerate == $past(out_degenerate)), "rows out of order")

    // After the final row, the next row shown opens a new matrix.
    `LAVM_ASSERT_NXT(a_restart, out_valid && out_ready && out_last_row, !out_valid || (out_row_index == lavm_pkg::ROW_FIRST), "matrix does not start at row zero")

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_row_index  (rsp.row_index),
    .out_col0       (rsp.col0),
    .out_col1       (rsp.col1),
    .out_col2       (rsp.col2),
    .out_col3       (rsp.col3),
    .out_degenerate (rsp.degenerate),
    .out_last_row   (rsp.last_row)
);

`default_nettype wire
